/* hw/rtl/u2d_pkg.sv */
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 8;
   localparam int CHAR_W     = 6;
   localparam int BCD_W      = 4;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [BCD_W-1:0] digit;
      logic             last;
   } digit_word_type;

endpackage

`default_nettype wire

/* hw/rtl/u2d_bcd_step.sv */
// ----------------------------------------------------------------------------
// u2d_bcd_step
// One shift-add-3 step: correct every BCD digit, then shift in one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_bcd_step #(
   parameter int DIGITS = 20
) (
   input  wire logic [DIGITS*4-1:0] bcd_cur,
   input  wire logic                bit_in,
   output logic      [DIGITS*4-1:0] bcd_nxt
);
   import u2d_pkg::*;

   logic [DIGITS*BCD_W-1:0] adjusted;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_cur[i*BCD_W +: BCD_W] >= 4'd5) begin
            adjusted[i*BCD_W +: BCD_W] = bcd_cur[i*BCD_W +: BCD_W] + 4'd3;
         end else begin
            adjusted[i*BCD_W +: BCD_W] = bcd_cur[i*BCD_W +: BCD_W];
         end
      end
      bcd_nxt = {adjusted[DIGITS*BCD_W-2:0], bit_in};
   end

endmodule

`default_nettype wire

/* hw/rtl/u2d_out_reg.sv */
// ----------------------------------------------------------------------------
// u2d_out_reg
// Result register: holds one ASCII digit word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire u2d_pkg::digit_word_type word_in,
   output logic                         slot_free,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [u2d_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [5:0] digit_char, [7:6] zero
   output logic                         rsp_tlast     // last_digit
);
   import u2d_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, word_in.digit};
         last_ff <= word_in.last;
      end
   end

   assign slot_free  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CHAR_W){1'b0}}, char_ff};
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/u64_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// u64_to_decimal_ascii
// Converts an unsigned binary word to its decimal ASCII text, most
// significant digit first, no leading zeros, tlast on the final digit.
// ----------------------------------------------------------------------------
// Sequence: an accept state, a shift-add-3 pass over every value bit through the
// shared BCD step unit, a skip state that drops each leading zero, then one
// digit per cycle into the result register while it has a free slot.
// One word in flight; req_tready is high only while idle.
// Synchronous active-high reset clears the sequencer and the result valid.
`default_nettype none

module u64_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [u2d_pkg::REQ_DATA_W-1:0] req_tdata,   // [63:0] number_in
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [u2d_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [5:0] digit_char
   output logic                                rsp_tlast    // last_digit
);
   import u2d_pkg::*;

   localparam int BCD_TOTAL = MAX_DIGITS * BCD_W;
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [BCD_TOTAL-1:0]   bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;

   logic [BCD_TOTAL-1:0]   bcd_step;
   logic [BCD_W-1:0]       top_digit;
   logic [BCD_TOTAL-1:0]   bcd_shifted;
   logic                   slot_free;
   logic                   load;
   digit_word_type         word;

   u2d_bcd_step #(
      .DIGITS (MAX_DIGITS)
   ) u_step (
      .bcd_cur (bcd_ff),
      .bit_in  (value_ff[VALUE_WIDTH-1]),
      .bcd_nxt (bcd_step)
   );

   assign top_digit   = bcd_ff[BCD_TOTAL-1 -: BCD_W];
   assign bcd_shifted = {bcd_ff[BCD_TOTAL-BCD_W-1:0], {BCD_W{1'b0}}};
   assign word.digit  = top_digit;
   assign word.last   = (dig_cnt_ff == DIG_CNT_W'(1));

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      req_tready = 1'b0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               value_in   = req_tdata[VALUE_WIDTH-1:0];
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
               dig_cnt_in = DIG_CNT_W'(MAX_DIGITS);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in     = bcd_step;
            value_in   = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (top_digit == '0 && dig_cnt_ff != DIG_CNT_W'(1)) begin
               bcd_in     = bcd_shifted;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load       = 1'b1;
               bcd_in     = bcd_shifted;
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
               if (word.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   u2d_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .word_in    (word),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Feeds 64-bit words into the decimal ASCII converter and checks every
// character word, and its tlast flag, against a digit predictor. Bursty
// input, patterned output stalls, up to two long output holds and drain pauses.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   import u2d_pkg::*;

   typedef struct {
      logic [63:0] number;
      bit          drain_first;
   } number_item_type;

   typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } char_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   number_item_type pending_numbers[$];
   char_word_type   expected_chars[$];
   int              mismatch_count = 0;
   int              chars_checked  = 0;

   int              burst_left = 0;
   int              gap_left   = 0;
   number_item_type next_item;
   bit              offer;

   int              hold_left  = 0;
   int              holds_done = 0;
   int              stall_mode = 0;
   int              mode_left  = 0;
   char_word_type   want;

   u64_to_decimal_ascii uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void predict_decimal_text(input logic [63:0] number);
      logic [63:0]   rest;
      logic [3:0]    digits [0:19];
      int            count;
      char_word_type word;
      rest  = number;
      count = 0;
      do begin
         digits[count] = 4'(rest % 64'd10);
         rest          = rest / 64'd10;
         count++;
      end while (rest != 0);
      for (int k = count - 1; k >= 0; k--) begin
         word.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
         word.last_digit = (k == 0);
         expected_chars.push_back(word);
      end
   endfunction

   function automatic logic [63:0] ten_to(input int exponent);
      logic [63:0] value;
      value = 64'd1;
      for (int k = 0; k < exponent; k++) value = value * 64'd10;
      return value;
   endfunction

   function automatic void add_number(input logic [63:0] number, input bit drain_first);
      number_item_type item;
      item.number      = number;
      item.drain_first = drain_first;
      pending_numbers.push_back(item);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_decimal_text(req_tdata);
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_numbers.size() != 0 &&
                         !(pending_numbers[0].drain_first && expected_chars.size() != 0)) begin
               next_item = pending_numbers.pop_front();
               req_tdata <= next_item.number;
               offer     = 1'b1;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 8);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
            req_tvalid <= offer;
         end
      end
   end

   // long output holds, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && chars_checked >= 200) ||
                   (holds_done == 1 && chars_checked >= 1200)) begin
         hold_left  <= 400;
         holds_done <= holds_done + 1;
      end
   end

   // monitor: check each character word, stall on a changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            chars_checked <= chars_checked + 1;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected word tdata=%0d tlast=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.digit_char)
                  report_mismatch($sformatf("digit_char %0d, expected %0d",
                                            rsp_tdata[CHAR_W-1:0], want.digit_char));
               if (rsp_tlast !== want.last_digit)
                  report_mismatch($sformatf("last_digit %0b, expected %0b",
                                            rsp_tlast, want.last_digit));
            end
         end
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (hold_left > 0)
            rsp_tready <= 1'b0;
         else if (stall_mode == 0)
            rsp_tready <= 1'b1;
         else if (stall_mode == 1)
            rsp_tready <= $urandom_range(0, 1);
         else
            rsp_tready <= ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      logic [63:0] value;
      int          bits;

      add_number(64'd0, 1'b0);
      add_number(64'd1, 1'b0);
      add_number(64'd9, 1'b0);
      add_number(64'd10, 1'b0);
      add_number(64'd11, 1'b0);
      add_number(64'd99, 1'b0);
      add_number(64'd100, 1'b0);
      add_number(64'd42, 1'b0);
      add_number(64'd1000000007, 1'b0);
      add_number(64'd4294967295, 1'b0);
      add_number(64'd4294967296, 1'b0);
      add_number(64'd18446744073709551615, 1'b0);
      add_number(64'd18446744073709551614, 1'b0);
      add_number(64'd10000000000000000000, 1'b1);
      add_number(64'd9999999999999999999, 1'b0);
      add_number(64'd9223372036854775808, 1'b0);
      add_number(64'd9223372036854775807, 1'b0);
      add_number(64'd12345678901234567890, 1'b0);
      add_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      add_number(64'h5555_5555_5555_5555, 1'b0);
      add_number(64'd0, 1'b1);

      for (int k = 0; k < 160; k++) begin
         case ($urandom_range(0, 3))
            0: value = {$urandom, $urandom};
            1: begin
               bits  = $urandom_range(1, 64);
               value = {$urandom, $urandom} & ({64{1'b1}} >> (64 - bits));
            end
            2: value = ten_to($urandom_range(1, 19)) - 64'd2 + 64'($urandom_range(0, 4));
            default: value = 64'($urandom_range(0, 999));
         endcase
         add_number(value, (k % 60) == 59);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() != 0 || req_tvalid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (150) @(negedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
